[src/gfa_pkg.sv]
`timescale 1ns / 1ps

package gfa_pkg;

    // field widths
    localparam int PIX_W  = 8;
    localparam int SIDE_W = 9;
    localparam int MAXV_W = 8;
    localparam int CHAR_W = 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VAL    = 2'd3;

    // register reset values
    localparam logic [SIDE_W-1:0] SRC_WIDTH_RST  = 9'd64;
    localparam logic [SIDE_W-1:0] SRC_HEIGHT_RST = 9'd64;
    localparam logic [SIDE_W-1:0] OUT_WIDTH_RST  = 9'd100;
    localparam logic [MAXV_W-1:0] MAX_VAL_RST    = 8'd255;

    // item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam int RAMP_TOP = 9;
    localparam int PIX_MAX  = 255;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } q_entry_t;

    // brightness ramp, darkest first
    function automatic logic [CHAR_W-1:0] ramp_char(input logic [3:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = 7'h20;
            4'd1:    c = 7'h2E;
            4'd2:    c = 7'h3A;
            4'd3:    c = 7'h2D;
            4'd4:    c = 7'h3D;
            4'd5:    c = 7'h2B;
            4'd6:    c = 7'h2A;
            4'd7:    c = 7'h23;
            4'd8:    c = 7'h25;
            default: c = 7'h40;
        endcase
        return c;
    endfunction

endpackage

[src/gfa_front.sv]
`timescale 1ns / 1ps

// Input side: tags each beat as load or emit and buffers it in a 2-deep queue.
module gfa_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gfa_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
    input  logic [0:0]                    s_tuser,   // [0] func
    output logic                          q_valid,
    output gfa_pkg::q_entry_t             q_entry,
    input  logic                          q_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gfa_pkg::q_entry_t slot_reg [DEPTH];
    gfa_pkg::q_entry_t in_entry;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;

    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        in_entry.op    = s_tuser[0] ? gfa_pkg::OP_EMIT : gfa_pkg::OP_LOAD;
        in_entry.pixel = s_tdata;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[src/gfa_div.sv]
`timescale 1ns / 1ps

// Restoring divider, two quotient bits per cycle. Denominator must be nonzero.
module gfa_div
#(
    parameter int NUM_W = 24,   // even
    parameter int DEN_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int STEPS = NUM_W / 2;
    localparam int STP_W = $clog2(STEPS);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [STP_W-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W-1:0] rem_s   [0:2];
    logic [NUM_W-1:0] quo_s   [0:2];
    logic [DEN_W:0]   trial_s [0:1];

    always_comb
    begin
        rem_s[0] = rem_reg;
        quo_s[0] = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial_s[i] = {rem_s[i], quo_s[i][NUM_W-1]};
            if (trial_s[i] >= {1'b0, den_reg})
            begin
                rem_s[i+1] = DEN_W'(trial_s[i] - {1'b0, den_reg});
                quo_s[i+1] = {quo_s[i][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_s[i+1] = trial_s[i][DEN_W-1:0];
                quo_s[i+1] = {quo_s[i][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == STP_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STP_W'(1);
                if (step_reg == STP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_s[2];
            quo_reg <= quo_s[2];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

[src/gfa_back.sv]
`timescale 1ns / 1ps

// Execution side: frame store, load counting, resampling math and output register.
module gfa_back
#(
    parameter int MAX_SIDE = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  gfa_pkg::q_entry_t              q_entry,
    output logic                           q_pop,
    input  logic [gfa_pkg::SIDE_W-1:0]     src_width,
    input  logic [gfa_pkg::SIDE_W-1:0]     src_height,
    input  logic [gfa_pkg::SIDE_W-1:0]     out_width,
    input  logic [gfa_pkg::MAXV_W-1:0]     max_val,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [gfa_pkg::CHAR_W-1:0]     res_char,
    output logic                           res_line_end,
    output logic                           res_frame_end
);

    localparam int SW       = gfa_pkg::SIDE_W;
    localparam int SIDE_EFF = (MAX_SIDE < 511) ? MAX_SIDE : 511;
    localparam int DEPTH    = SIDE_EFF * SIDE_EFF;
    localparam int AW       = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int RT_MAX   = DEPTH * 11 / 20;
    localparam int RT_W     = $clog2(RT_MAX + 1);
    localparam int N_RT     = $clog2(DEPTH * 11 + 1);
    localparam int N_OY     = $clog2(RT_MAX * SIDE_EFF + 1);
    localparam int N_BR     = $clog2(gfa_pkg::PIX_MAX * gfa_pkg::RAMP_TOP + 1);
    localparam int N_A      = (N_RT > N_OY) ? N_RT : N_OY;
    localparam int N_MAX    = (N_A > N_BR) ? N_A : N_BR;
    localparam int NUM_W    = N_MAX + (N_MAX % 2);
    localparam int D_RT     = $clog2(20 * SIDE_EFF + 1);
    localparam int D_A      = (D_RT > RT_W) ? D_RT : RT_W;
    localparam int D_B      = (SW > gfa_pkg::MAXV_W) ? SW : gfa_pkg::MAXV_W;
    localparam int DEN_W    = (D_A > D_B) ? D_A : D_B;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RT    = 4'd1;   // row count division
    localparam logic [3:0] ST_OX    = 4'd2;   // source column division
    localparam logic [3:0] ST_OY    = 4'd3;   // source row division
    localparam logic [3:0] ST_ADDR  = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_BR    = 4'd6;
    localparam logic [3:0] ST_BRDIV = 4'd7;   // ramp index division

    // clamped settings
    logic [SW-1:0]                 w, h, ow;
    logic [gfa_pkg::MAXV_W-1:0]    mv;

    always_comb
    begin
        w  = (src_width == '0) ? SW'(1) :
             (32'(src_width) > MAX_SIDE) ? SW'(SIDE_EFF) : src_width;
        h  = (src_height == '0) ? SW'(1) :
             (32'(src_height) > MAX_SIDE) ? SW'(SIDE_EFF) : src_height;
        ow = (out_width == '0) ? SW'(1) :
             (32'(out_width) > MAX_SIDE) ? SW'(SIDE_EFF) : out_width;
        mv = (max_val == '0) ? gfa_pkg::MAXV_W'(1) : max_val;
    end

    // settings products, refreshed every cycle
    logic [CNT_W-1:0]   total_reg;
    logic [2*SW-1:0]    hw_reg;
    logic [NUM_W-1:0]   rt_num;
    logic [DEN_W-1:0]   rt_den;

    always_ff @(posedge clk)
    begin
        total_reg <= CNT_W'({{SW{1'b0}}, w} * {{SW{1'b0}}, h});
        hw_reg    <= {{SW{1'b0}}, h} * {{SW{1'b0}}, ow};
    end

    assign rt_num = NUM_W'({hw_reg, 3'b000}) + NUM_W'({hw_reg, 1'b0}) + NUM_W'(hw_reg);
    assign rt_den = DEN_W'({w, 4'b0000}) + DEN_W'({w, 2'b00});

    // state
    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   load_count_reg, load_count_next;
    logic               frame_ready_reg, frame_ready_next;
    logic [RT_W-1:0]    row_total_reg, row_total_next;
    logic [SW-1:0]      out_col_reg, out_col_next;
    logic [RT_W-1:0]    out_row_reg, out_row_next;
    logic               res_valid_reg, res_valid_next;
    logic               div_start_reg, div_start_next;

    // payload
    logic [NUM_W-1:0]               div_num_reg, div_num_next;
    logic [DEN_W-1:0]               div_den_reg, div_den_next;
    logic [SW-1:0]                  ox_reg, ox_next;
    logic [SW-1:0]                  oy_reg, oy_next;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [gfa_pkg::CHAR_W-1:0]     res_char_reg, res_char_next;
    logic                           res_line_end_reg, res_line_end_next;
    logic                           res_frame_end_reg, res_frame_end_next;
    logic [gfa_pkg::PIX_W-1:0]      rd_data_reg;

    logic [CNT_W-1:0]   lc_eff, lc_new;
    logic               mem_we;
    logic               res_load;
    logic [3:0]         ramp_idx;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;

    logic [gfa_pkg::PIX_W-1:0] store_mem [DEPTH];

    gfa_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next         = state_reg;
        load_count_next    = load_count_reg;
        frame_ready_next   = frame_ready_reg;
        row_total_next     = row_total_reg;
        out_col_next       = out_col_reg;
        out_row_next       = out_row_reg;
        div_start_next     = 1'b0;
        div_num_next       = div_num_reg;
        div_den_next       = div_den_reg;
        ox_next            = ox_reg;
        oy_next            = oy_reg;
        addr_next          = addr_reg;
        res_char_next      = res_char_reg;
        res_line_end_next  = res_line_end_reg;
        res_frame_end_next = res_frame_end_reg;
        q_pop              = 1'b0;
        mem_we             = 1'b0;
        res_load           = 1'b0;
        lc_eff             = frame_ready_reg ? '0 : load_count_reg;
        lc_new             = lc_eff;
        ramp_idx           = (div_quo > NUM_W'(gfa_pkg::RAMP_TOP)) ?
                             4'(gfa_pkg::RAMP_TOP) : div_quo[3:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_entry.op == gfa_pkg::OP_LOAD || !res_valid_reg))
                begin
                    q_pop = 1'b1;
                    if (q_entry.op == gfa_pkg::OP_LOAD)
                    begin
                        // a load after a finished frame starts a new one
                        frame_ready_next = 1'b0;
                        if (lc_eff < total_reg)
                        begin
                            mem_we = 1'b1;
                            lc_new = lc_eff + CNT_W'(1);
                        end
                        load_count_next = lc_new;
                        if (lc_new >= total_reg)
                        begin
                            div_start_next = 1'b1;
                            div_num_next   = rt_num;
                            div_den_next   = rt_den;
                            state_next     = ST_RT;
                        end
                    end
                    else if (frame_ready_reg && (out_row_reg < row_total_reg))
                    begin
                        if (out_col_reg < ow)
                        begin
                            div_start_next = 1'b1;
                            div_num_next   = NUM_W'({{SW{1'b0}}, out_col_reg} *
                                                    {{SW{1'b0}}, w});
                            div_den_next   = DEN_W'(ow);
                            state_next     = ST_OX;
                        end
                        else
                        begin
                            // end of row
                            res_load           = 1'b1;
                            res_char_next      = gfa_pkg::NEWLINE_CODE;
                            res_line_end_next  = 1'b1;
                            res_frame_end_next = (({1'b0, out_row_reg} + (RT_W+1)'(1)) ==
                                                  {1'b0, row_total_reg});
                            out_col_next       = '0;
                            out_row_next       = out_row_reg + RT_W'(1);
                        end
                    end
                end
            end
            ST_RT:
            begin
                if (div_done)
                begin
                    row_total_next   = div_quo[RT_W-1:0];
                    frame_ready_next = 1'b1;
                    out_col_next     = '0;
                    out_row_next     = '0;
                    state_next       = ST_IDLE;
                end
            end
            ST_OX:
            begin
                if (div_done)
                begin
                    ox_next        = div_quo[SW-1:0];
                    div_start_next = 1'b1;
                    div_num_next   = NUM_W'({{SW{1'b0}}, out_row_reg} *
                                            {{RT_W{1'b0}}, h});
                    div_den_next   = DEN_W'(row_total_reg);
                    state_next     = ST_OY;
                end
            end
            ST_OY:
            begin
                if (div_done)
                begin
                    oy_next    = div_quo[SW-1:0];
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                addr_next  = AW'({{SW{1'b0}}, oy_reg} * {{SW{1'b0}}, w} +
                                 {{SW{1'b0}}, ox_reg});
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_BR;
            end
            ST_BR:
            begin
                div_start_next = 1'b1;
                div_num_next   = NUM_W'({rd_data_reg, 3'b000}) + NUM_W'(rd_data_reg);
                div_den_next   = DEN_W'(mv);
                state_next     = ST_BRDIV;
            end
            ST_BRDIV:
            begin
                if (div_done)
                begin
                    res_load           = 1'b1;
                    res_char_next      = gfa_pkg::ramp_char(ramp_idx);
                    res_line_end_next  = 1'b0;
                    res_frame_end_next = 1'b0;
                    out_col_next       = out_col_reg + SW'(1);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            load_count_reg  <= '0;
            frame_ready_reg <= 1'b0;
            row_total_reg   <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            res_valid_reg   <= 1'b0;
            div_start_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_count_reg  <= load_count_next;
            frame_ready_reg <= frame_ready_next;
            row_total_reg   <= row_total_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            res_valid_reg   <= res_valid_next;
            div_start_reg   <= div_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg       <= div_num_next;
        div_den_reg       <= div_den_next;
        ox_reg            <= ox_next;
        oy_reg            <= oy_next;
        addr_reg          <= addr_next;
        res_char_reg      <= res_char_next;
        res_line_end_reg  <= res_line_end_next;
        res_frame_end_reg <= res_frame_end_next;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[lc_eff[AW-1:0]] <= q_entry.pixel;
        end
        rd_data_reg <= store_mem[addr_reg];
    end

    assign res_valid     = res_valid_reg;
    assign res_char      = res_char_reg;
    assign res_line_end  = res_line_end_reg;
    assign res_frame_end = res_frame_end_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !res_valid_reg)
        else $error("result written over a pending beat");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> (out_row_reg <= row_total_reg))
        else $error("output row ran past row count");

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RT || state_reg == ST_OX ||
                      state_reg == ST_OY || state_reg == ST_BRDIV))
        else $error("divider finished outside a waiting state");
`endif

endmodule

[src/gray_frame_to_ascii_ramp.sv]
`timescale 1ns / 1ps

// Grayscale frame to ASCII art, nearest-neighbor resampled, 10-step brightness ramp.
// Input stream s_*: tuser[0] = 0 loads the next pixel (tdata) in raster order;
//   tuser[0] = 1 asks for the next character of the picture.
// Output stream m_*: tdata[6:0] is the character, tuser[0] marks a row newline,
//   tlast marks the newline that closes the frame. Emit requests before a frame
//   is complete, or after its last newline, give no beat.
// Config channel cfg_*: index 0 src_width, 1 src_height, 2 out_width, 3 max_val;
//   always ready, write only while the block is idle.
// A 2-deep input queue takes beats while the back end works or the output
//   register waits on m_tready; a stalled receiver holds the result and, once
//   the queue fills, s_tready drops.
// Path of an input beat, back end idle; every division runs on the shared radix-4
//   divider (NUM_W = 24 at MAX_SIDE = 256): a pixel passes from the queue into the
//   store; the last pixel of a frame adds the row division before the frame is ready;
//   a character takes the column and row divisions, the store read and the ramp
//   division before m_tvalid; a newline goes straight to the output register. One item at a time.
// Reset clears all counters and the frame-complete flag; the registers return
//   to 64, 64, 100, 255. The frame store is not cleared.
module gray_frame_to_ascii_ramp
#(
    parameter int MAX_SIDE = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,    // [7:0] pixel
    input  logic [0:0]                         s_tuser,    // [0] func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,    // [6:0] char_code, [7] zero
    output logic [0:0]                         m_tuser,    // [0] line_end
    output logic                               m_tlast,    // frame_end
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gfa_pkg::SIDE_W-1:0]         cfg_data
);

    logic [gfa_pkg::SIDE_W-1:0]  src_width_reg;
    logic [gfa_pkg::SIDE_W-1:0]  src_height_reg;
    logic [gfa_pkg::SIDE_W-1:0]  out_width_reg;
    logic [gfa_pkg::MAXV_W-1:0]  max_val_reg;

    logic                        q_valid;
    logic                        q_pop;
    gfa_pkg::q_entry_t           q_entry;
    logic [gfa_pkg::CHAR_W-1:0]  res_char;
    logic                        res_line_end;

    assign cfg_ready = 1'b1;

    // register file; upper data bits are dropped for max_val
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= gfa_pkg::SRC_WIDTH_RST;
            src_height_reg <= gfa_pkg::SRC_HEIGHT_RST;
            out_width_reg  <= gfa_pkg::OUT_WIDTH_RST;
            max_val_reg    <= gfa_pkg::MAX_VAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gfa_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                gfa_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                gfa_pkg::REG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                gfa_pkg::REG_MAX_VAL:    max_val_reg    <= cfg_data[gfa_pkg::MAXV_W-1:0];
                default:                 ;
            endcase
        end
    end

    gfa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    gfa_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .src_width     (src_width_reg),
        .src_height    (src_height_reg),
        .out_width     (out_width_reg),
        .max_val       (max_val_reg),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_char      (res_char),
        .res_line_end  (res_line_end),
        .res_frame_end (m_tlast)
    );

    assign m_tdata    = {1'b0, res_char};
    assign m_tuser[0] = res_line_end;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int SIDE_MAX    = 256;
    localparam int ITEM_GOAL   = 1450;
    localparam int SETTLE_CYC  = 200;   // covers a full input queue of character requests
    localparam int LONG_HOLD   = 400;   // receiver hold-off, long enough to back up s_tready
    localparam int STALL_LIMIT = 5000;  // cycles with no beat on any channel
    localparam int MAX_EMITS   = 72;    // cap on character requests per frame

    // ramp, darkest first; entry i sits at bits [8*(9-i) +: 8]
    localparam logic [79:0] SHADES = " .:-=+*#%@";

    typedef struct packed {
        logic [gfa_pkg::CHAR_W-1:0] code;
        logic                       nl;
        logic                       fin;
    } glyph_t;

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_style_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;    // [7:0] pixel
    logic [0:0]                    s_tuser   = '0;    // [0] func
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [7:0]                    m_tdata;           // [6:0] char_code, [7] zero
    logic [0:0]                    m_tuser;           // [0] line_end
    logic                          m_tlast;           // frame_end
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [gfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gfa_pkg::SIDE_W-1:0]    cfg_data  = '0;

    gray_frame_to_ascii_ramp #(.MAX_SIDE(SIDE_MAX)) dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Picture model: register mirror, frame store, emit position
    // ---------------------------------------------------------------
    logic [gfa_pkg::SIDE_W-1:0] reg_sw = gfa_pkg::SRC_WIDTH_RST;
    logic [gfa_pkg::SIDE_W-1:0] reg_sh = gfa_pkg::SRC_HEIGHT_RST;
    logic [gfa_pkg::SIDE_W-1:0] reg_ow = gfa_pkg::OUT_WIDTH_RST;
    logic [gfa_pkg::MAXV_W-1:0] reg_mv = gfa_pkg::MAX_VAL_RST;

    logic [gfa_pkg::PIX_W-1:0] gray_mem [0:SIDE_MAX*SIDE_MAX-1];
    int unsigned pix_loaded = 0;
    bit          pic_done   = 1'b0;
    int unsigned pic_rows   = 0;
    int unsigned pic_col    = 0;
    int unsigned pic_row    = 0;

    glyph_t              due_glyphs [$];     // characters the block still owes us
    gfa_pkg::q_entry_t   pending_items [$];  // beats waiting for the input bus
    int                  items_sent = 0;
    int                  err_cnt    = 0;

    // zero reads as 1, anything past the store side reads as the side
    function automatic int unsigned side_of(input logic [gfa_pkg::SIDE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SIDE_MAX)
            return SIDE_MAX;
        return v;
    endfunction

    // rows = floor(h * ow * 0.55 / w), kept exact in integers
    function automatic int unsigned rows_of(input int unsigned w, h, ow);
        return (h * ow * 11) / (20 * w);
    endfunction

    task automatic render_step(input logic op, input logic [gfa_pkg::PIX_W-1:0] pix);
        int unsigned w, h, ow, total, ox, oy, mvv, lvl;
        glyph_t      g;
        w     = side_of(reg_sw);
        h     = side_of(reg_sh);
        ow    = side_of(reg_ow);
        total = w * h;
        if (op == gfa_pkg::OP_LOAD)
        begin
            // a load on a finished frame opens a new one
            if (pic_done)
            begin
                pic_done   = 1'b0;
                pix_loaded = 0;
            end
            // registers may have shrunk under a partial frame: store nothing then
            if (pix_loaded < total)
            begin
                gray_mem[pix_loaded] = pix;
                pix_loaded++;
            end
            if (pix_loaded >= total)
            begin
                pic_done = 1'b1;
                pic_rows = rows_of(w, h, ow);
                pic_col  = 0;
                pic_row  = 0;
            end
        end
        else if (pic_done && pic_row < pic_rows)
        begin
            if (pic_col < ow)
            begin
                ox  = (pic_col * w) / ow;
                oy  = (pic_row * h) / pic_rows;
                mvv = (reg_mv == 0) ? 1 : reg_mv;
                lvl = (gray_mem[oy * w + ox] * gfa_pkg::RAMP_TOP) / mvv;
                if (lvl > gfa_pkg::RAMP_TOP)
                    lvl = gfa_pkg::RAMP_TOP;
                g.code = SHADES[8 * (gfa_pkg::RAMP_TOP - lvl) +: gfa_pkg::CHAR_W];
                g.nl   = 1'b0;
                g.fin  = 1'b0;
                pic_col++;
            end
            else
            begin
                // also taken when out_width shrank below the current column
                g.code = gfa_pkg::NEWLINE_CODE;
                g.nl   = 1'b1;
                g.fin  = (pic_row + 1 == pic_rows);
                pic_col = 0;
                pic_row++;
            end
            due_glyphs.push_back(g);
        end
        // emits before completion or past the last row give nothing
    endtask

    // ---------------------------------------------------------------
    // Input driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        gfa_pkg::q_entry_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                render_step(s_tuser[0], s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.pixel;
                    s_tuser  <= nxt.op;
                    if (burst_left <= 1)
                    begin
                        // zero gap merges bursts into long unbroken stretches
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output receiver: changing stall styles plus two long hold-offs
    // ---------------------------------------------------------------
    int        rx_beats = 0;
    int        rx_holds = 0;
    int        rx_hold  = 0;
    int        rx_span  = 0;
    rx_style_t rx_mode  = RX_OPEN;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                rx_beats++;
                // plenty still queued to send, so the block fills and drops s_tready
                if (rx_holds < 2 && rx_beats >= 100 && pending_items.size() >= 8)
                begin
                    rx_hold = LONG_HOLD;
                    rx_holds++;
                end
            end
            if (rx_hold != 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_span == 0)
                begin
                    rx_mode = rx_style_t'($urandom_range(0, 2));
                    rx_span = $urandom_range(16, 128);
                end
                rx_span--;
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_CHOPPY: m_tready <= 1'($urandom);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Output check against the oldest owed character
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_glyphs.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: beat with nothing owed: tdata=%h tuser=%b tlast=%b",
                             $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = due_glyphs.pop_front();
                if (m_tdata !== {1'b0, want.code} || m_tuser[0] !== want.nl
                    || m_tlast !== want.fin)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: expected tdata=%h tuser=%b tlast=%b, got %h %b %b",
                                 $time, {1'b0, want.code}, want.nl, want.fin,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long with no beat anywhere
    // ---------------------------------------------------------------
    int idle_cyc = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cyc <= 0;
        else if (idle_cyc >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cyc <= idle_cyc + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [gfa_pkg::PIX_W-1:0] rand_gray();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_load(input logic [gfa_pkg::PIX_W-1:0] pix);
        pending_items.push_back({gfa_pkg::OP_LOAD, pix});
        items_sent++;
    endtask

    // pixel field is don't-care on a request; randomize it anyway
    task automatic push_emits(input int n);
        repeat (n)
        begin
            pending_items.push_back({gfa_pkg::OP_EMIT, 8'($urandom)});
            items_sent++;
        end
    endtask

    // raster load with a few stray requests after loads (nothing until the frame is whole)
    task automatic load_pixels(input int n);
        repeat (n)
        begin
            push_load(rand_gray());
            if ($urandom_range(0, 15) == 0)
                push_emits(1);
        end
    endtask

    // stop sending, collect every owed character, let the back end go idle
    task automatic quiesce();
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || due_glyphs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [gfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gfa_pkg::SIDE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            gfa_pkg::REG_SRC_WIDTH:  reg_sw = val;
            gfa_pkg::REG_SRC_HEIGHT: reg_sh = val;
            gfa_pkg::REG_OUT_WIDTH:  reg_ow = val;
            default:                 reg_mv = val[gfa_pkg::MAXV_W-1:0];   // bit 8 ignored
        endcase
    endtask

    task automatic set_geometry(input logic [gfa_pkg::SIDE_W-1:0] sw, sh, ow, mvd);
        write_reg(gfa_pkg::REG_SRC_WIDTH, sw);
        write_reg(gfa_pkg::REG_SRC_HEIGHT, sh);
        write_reg(gfa_pkg::REG_OUT_WIDTH, ow);
        write_reg(gfa_pkg::REG_MAX_VAL, mvd);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [gfa_pkg::SIDE_W-1:0] sw, sh, ow, mvd;
        logic [gfa_pkg::MAXV_W-1:0] mv;
        int unsigned                total, full, n, p, k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // request before any frame exists: no beat
        push_emits(1);
        quiesce();

        // 1x1 source (width 0 reads as 1), max_val 0 with bit 8 set reads as 1
        set_geometry(9'd0, 9'd1, 9'd2, 9'h100);
        push_load(8'h00);
        push_emits(3);              // two blanks, newline closing the frame
        push_emits(1);              // past the frame end: nothing
        push_load(8'hFF);           // reload on a finished frame, saturates the ramp
        push_emits(3);
        quiesce();

        // 1x1 into one column gives zero rows: requests give nothing
        set_geometry(9'd1, 9'd1, 9'd1, 9'd255);
        push_load(8'h80);
        push_emits(1);
        quiesce();

        // partial 2x2 frame, then shrink the width so the next load completes it
        set_geometry(9'd2, 9'd2, 9'd4, 9'd200);
        push_load(8'h00);
        push_load(8'd200);
        push_load(8'd199);
        quiesce();
        write_reg(gfa_pkg::REG_SRC_WIDTH, 9'd1);
        push_load(8'h5A);           // stores nothing, closes the frame
        push_emits(3);
        quiesce();
        // narrow the rows under the current column: next request is the newline
        write_reg(gfa_pkg::REG_OUT_WIDTH, 9'd2);
        push_emits(2);

        // random frames
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                quiesce();
                case ($urandom_range(0, 15))
                    0:
                    begin
                        sw = $urandom_range(0, 1) ? 9'd256 : 9'd511;
                        sh = 9'($urandom_range(0, 1));
                    end
                    1:
                    begin
                        sw = 9'($urandom_range(0, 1));
                        sh = $urandom_range(0, 1) ? 9'd256 : 9'd511;
                    end
                    default:
                    begin
                        sw = 9'($urandom_range(1, 8));
                        sh = 9'($urandom_range(1, 8));
                    end
                endcase
                case ($urandom_range(0, 9))
                    0:       ow = 9'd0;
                    1:       ow = $urandom_range(0, 1) ? 9'd256 : 9'd511;
                    default: ow = 9'($urandom_range(1, 24));
                endcase
                case ($urandom_range(0, 5))
                    0:       mv = 8'd0;
                    1:       mv = 8'd255;
                    2:       mv = 8'd1;
                    default: mv = 8'($urandom_range(1, 255));
                endcase
                mvd = {1'($urandom), mv};
                set_geometry(sw, sh, ow, mvd);
            end

            total = side_of(reg_sw) * side_of(reg_sh);
            if (total > 1 && $urandom_range(0, 7) == 0)
            begin
                // broken frame: registers shrink below what is already loaded
                p = $urandom_range(1, total - 1);
                load_pixels(p);
                quiesce();
                k = $urandom_range(1, (p < SIDE_MAX) ? p : SIDE_MAX);
                write_reg(gfa_pkg::REG_SRC_WIDTH, 9'd1);
                write_reg(gfa_pkg::REG_SRC_HEIGHT, 9'(k));
                push_load(rand_gray());
            end
            else
                load_pixels(total);

            // whole picture plus a request or two past its end, capped
            full = rows_of(side_of(reg_sw), side_of(reg_sh), side_of(reg_ow))
                   * (side_of(reg_ow) + 1);
            n = full + $urandom_range(0, 2);
            if (n > MAX_EMITS)
                n = MAX_EMITS;

            if (n > 1 && $urandom_range(0, 4) == 0)
            begin
                // change row width or brightness scale halfway through the picture
                push_emits(n / 2);
                quiesce();
                if ($urandom_range(0, 1))
                    write_reg(gfa_pkg::REG_OUT_WIDTH, 9'($urandom_range(0, 24)));
                else
                    write_reg(gfa_pkg::REG_MAX_VAL, 9'($urandom_range(0, 511)));
                push_emits(n - n / 2);
            end
            else
                push_emits(n);
        end

        quiesce();
        if (err_cnt == 0 && due_glyphs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
